// File: design/small_matrix_inverse_defines.svh
// ----------------------------------------------------------------------------
// small_matrix_inverse_defines.svh
// Assertion macros used by the matrix inverse top module.
// ----------------------------------------------------------------------------
`ifndef SMALL_MATRIX_INVERSE_DEFINES_SVH
`define SMALL_MATRIX_INVERSE_DEFINES_SVH
`ifndef SYNTH
// property must hold on every clock edge outside reset
`define SMI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// implication checked with no reset qualifier
`define SMI_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMI_ASSERT(label, clk, rst_n, prop, msg)
`define SMI_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// File: design/smi_pkg.sv
// ----------------------------------------------------------------------------
// smi_pkg
// Widths and the shared control struct of the small matrix inverse.
// ----------------------------------------------------------------------------
`default_nettype none
package smi_pkg;
  localparam int DW = 32;
  localparam int FB = 16;
  // cofactor/determinant magnitudes
  localparam int CW = 3 * DW + 2;
  // dividend magnitude: (2*|C|*2^(2FB)) + |D|
  localparam int NW = CW + 2 * FB + 2;
  localparam int N_ENT = 9;
  // quotient bits kept; larger values only saturate
  localparam int QW = DW + 1;
  // divider steps (one quotient bit each)
  localparam int NSTEP = QW;

  localparam logic [1:0] ORD_1 = 2'd1;
  localparam logic [1:0] ORD_2 = 2'd2;
  localparam logic [1:0] ORD_3 = 2'd3;

  typedef logic signed [DW-1:0] data_t;
  typedef logic signed [CW:0] big_t;

  // per-item status carried beside the divider
  typedef struct packed {
    logic sing;
    logic [N_ENT-1:0] neg;
    logic [N_ENT-1:0] big;
  } stat_t;
endpackage
`default_nettype wire

// File: design/small_matrix_inverse.sv
// ----------------------------------------------------------------------------
// small_matrix_inverse
// Inverse of a 1x1, 2x2 or 3x3 signed Q16.16 matrix by adjugate over det.
// ----------------------------------------------------------------------------
// Pipeline: 5 cofactor stages, 34 divider stages, 1 saturation/output
//   register.
// Throughput: one matrix per cycle; the whole pipeline advances together
//   and holds when the output register is full and not taken.
// Reset: synchronous active-low rst_n clears all valid bits.
`default_nettype none
`include "small_matrix_inverse_defines.svh"
module small_matrix_inverse (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic in_tready,
  // order[1:0], m00..m22 (32 each) at [33:2] .. [289:258], zero pad to 296
  input  wire logic [295:0] in_tdata,
  output logic out_tvalid,
  input  wire logic out_tready,
  // r00..r22 (32 each) at [31:0] .. [287:256], zero pad to 288
  output logic [287:0] out_tdata,
  // singular [0], overflow [1]
  output logic [1:0] out_tuser
);
  import smi_pkg::*;

  logic en;
  data_t m [9];
  logic cv;
  big_t cof [9];
  big_t det;
  logic dv;
  stat_t st;
  logic [QW-1:0] quo [9];
  logic ov_r;
  logic [287:0] od_r;
  logic [1:0] ou_r;

  // the pipeline moves whenever the output slot is free or being taken
  assign en = !ov_r || out_tready;
  assign in_tready = en;

  always_comb begin
    for (int i = 0; i < 9; i++) m[i] = data_t'(in_tdata[2 + 32*i +: 32]);
  end

  smi_cofactor u_cof (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(in_tvalid),
    .order(in_tdata[1:0]), .m(m), .vld_out(cv), .cof(cof), .det(det)
  );

  smi_divider u_div (
    .clk(clk), .rst_n(rst_n), .en(en), .vld_in(cv), .cof(cof), .det(det),
    .vld_out(dv), .st(st), .quo(quo)
  );

  // saturate, sign and register the result
  logic [287:0] od_nxt;
  logic ovf_nxt;
  always_comb begin
    logic [QW-1:0] lim;
    logic [QW-1:0] mg;
    od_nxt = '0;
    ovf_nxt = 1'b0;
    for (int i = 0; i < 9; i++) begin
      lim = st.neg[i] ? (QW'(1) << (DW-1)) : ((QW'(1) << (DW-1)) - QW'(1));
      mg = quo[i];
      if (st.big[i] || mg > lim) begin
        mg = lim;
        ovf_nxt = 1'b1;
      end
      od_nxt[32*i +: 32] = st.neg[i] ? DW'(-mg) : DW'(mg);
    end
    if (st.sing) begin
      od_nxt = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (en) ov_r <= dv;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      od_r <= od_nxt;
      ou_r <= {ovf_nxt, st.sing};
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

  `SMI_ASSERT(a_ready_free, clk, rst_n, !ov_r |-> in_tready, "ready low with empty output")
  `SMI_ASSERT(a_hold, clk, rst_n, (ov_r && !out_tready) |=> $stable(od_r), "result changed")
  `SMI_ASSERT(a_sing_zero, clk, rst_n, (ov_r && ou_r[0]) |-> (od_r == '0 && !ou_r[1]), "sing")
endmodule
`default_nettype wire

// File: design/smi_cofactor.sv
// ----------------------------------------------------------------------------
// smi_cofactor
// Five-stage pipeline: products, cofactors, split determinant products,
// determinant partials, determinant sum.
// ----------------------------------------------------------------------------
`default_nettype none
module smi_cofactor (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic vld_in,
  input  wire logic [1:0] order,
  input  wire smi_pkg::data_t m [9],
  output logic vld_out,
  output smi_pkg::big_t cof [9],
  output smi_pkg::big_t det
);
  import smi_pkg::*;

  // low slice width of a cofactor in the split determinant multiply
  localparam int LW = DW + 1;

  // product pairs in the order used by the cofactor stage
  localparam int PA [18] = '{4,5,2,1,1,2,5,3,0,2,2,0,3,4,1,0,0,1};
  localparam int PB [18] = '{8,7,7,8,5,4,6,8,8,6,3,5,7,6,6,7,4,3};

  logic [4:0] vld_r;
  logic [1:0] ord1_r, ord2_r;
  logic ord3_r;
  data_t a1_r [9];
  data_t a2_r [9];
  logic signed [2*DW-1:0] p_r [18];
  logic signed [2*DW+1:0] c2_r [9];
  big_t c3_nxt [9];
  big_t c3_r [9];
  big_t c4_r [9];
  logic signed [CW+1:0] dx_nxt, dx_r;
  logic signed [2*DW:0] ph_r [3];
  logic signed [2*DW+1:0] pl_r [3];
  logic signed [CW+1:0] d_nxt [3];
  logic signed [CW+1:0] d_r [3];
  big_t cof_r [9];
  big_t det_r;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[3:0], vld_in};
  end

  // stage 1: the 18 two-entry products
  always_ff @(posedge clk) begin
    if (en) begin
      ord1_r <= order;
      ord2_r <= ord1_r;
      a1_r <= m;
      a2_r <= a1_r;
      for (int i = 0; i < 18; i++) begin
        p_r[i] <= (2*DW)'(m[PA[i]]) * (2*DW)'(m[PB[i]]);
      end
    end
  end

  // stage 2: order-3 cofactors
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        c2_r[i] <= (2*DW+2)'(p_r[2*i]) - (2*DW+2)'(p_r[2*i+1]);
      end
    end
  end

  // stage 3: cofactor select and determinant for orders 1 and 2
  always_comb begin
    for (int i = 0; i < 9; i++) c3_nxt[i] = '0;
    dx_nxt = '0;
    case (ord2_r)
      ORD_1: begin
        c3_nxt[0] = big_t'(1);
        dx_nxt = (CW+2)'(a2_r[0]);
      end
      ORD_2: begin
        c3_nxt[0] = big_t'(a2_r[4]);
        c3_nxt[1] = -big_t'(a2_r[1]);
        c3_nxt[3] = -big_t'(a2_r[3]);
        c3_nxt[4] = big_t'(a2_r[0]);
        dx_nxt = (CW+2)'(c2_r[8]);
      end
      ORD_3: begin
        for (int i = 0; i < 9; i++) c3_nxt[i] = big_t'(c2_r[i]);
      end
      default: begin
        dx_nxt = '0;
      end
    endcase
  end

  // stage 3: entry times cofactor, split into high and low cofactor halves
  always_ff @(posedge clk) begin
    if (en) begin
      c3_r <= c3_nxt;
      dx_r <= dx_nxt;
      ord3_r <= (ord2_r == ORD_3);
      for (int j = 0; j < 3; j++) begin
        ph_r[j] <= (2*DW+1)'(a2_r[j]) * (2*DW+1)'($signed(c2_r[3*j][2*DW+1:LW]));
        pl_r[j] <= (2*DW+2)'(a2_r[j]) * (2*DW+2)'($signed({1'b0, c2_r[3*j][LW-1:0]}));
      end
    end
  end

  // stage 4: recombine the halves into the three determinant partials
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_nxt[j] = ((CW+2)'(ph_r[j]) <<< LW) + (CW+2)'(pl_r[j]);
    end
    if (!ord3_r) begin
      d_nxt[0] = dx_r;
      d_nxt[1] = '0;
      d_nxt[2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c4_r <= c3_r;
      d_r <= d_nxt;
    end
  end

  // stage 5 output register: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      cof_r <= c4_r;
      det_r <= big_t'(d_r[0] + d_r[1] + d_r[2]);
    end
  end

  assign vld_out = vld_r[4];
  assign cof = cof_r;
  assign det = det_r;
endmodule
`default_nettype wire

// File: design/smi_divider.sv
// ----------------------------------------------------------------------------
// smi_divider
// Pipelined restoring divider, one quotient bit per stage, nine lanes.
// ----------------------------------------------------------------------------
`default_nettype none
module smi_divider (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic vld_in,
  input  wire smi_pkg::big_t cof [9],
  input  wire smi_pkg::big_t det,
  output logic vld_out,
  output smi_pkg::stat_t st,
  output logic [smi_pkg::QW-1:0] quo [9]
);
  import smi_pkg::*;

  localparam int RW = CW + 3;

  logic [CW-1:0] dm;
  logic [NW-1:0] n2 [9];
  logic [N_ENT-1:0] big0, neg0;
  stat_t st0;

  // prepare: magnitudes, rounding offset, early overflow test
  always_comb begin
    dm = det[CW] ? CW'(-det) : det[CW-1:0];
    for (int i = 0; i < 9; i++) begin
      n2[i] = (NW'(cof[i][CW] ? CW'(-cof[i]) : cof[i][CW-1:0]) << (2*FB+1))
              + NW'(dm);
      big0[i] = (n2[i] >> (QW + 1)) >= NW'(dm);
      neg0[i] = (cof[i] != '0) && (cof[i][CW] != det[CW]);
    end
    st0.sing = (det == '0);
    st0.neg = neg0;
    st0.big = big0;
  end

  logic [NSTEP:0] v_r;
  stat_t s_r [NSTEP+1];
  logic [QW-1:0] n_r [NSTEP+1][9];
  logic [RW-1:0] rm_r [NSTEP+1][9];
  logic [QW-1:0] q_r [NSTEP+1][9];
  logic [CW:0] d2_r [NSTEP+1];

  // stage 0 captures operands
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= '0;
    else if (en) v_r <= {v_r[NSTEP-1:0], vld_in};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      s_r[0] <= st0;
      d2_r[0] <= {dm, 1'b0};
      for (int i = 0; i < 9; i++) begin
        n_r[0][i] <= n2[i][QW-1:0];
        rm_r[0][i] <= RW'(n2[i] >> QW);
        q_r[0][i] <= '0;
      end
    end
  end

  // one quotient bit per stage, MSB first
  for (genvar s = 0; s < NSTEP; s++) begin : g_step
    always_ff @(posedge clk) begin
      logic [RW-1:0] t;
      if (en) begin
        s_r[s+1] <= s_r[s];
        d2_r[s+1] <= d2_r[s];
        for (int i = 0; i < 9; i++) begin
          t = {rm_r[s][i][RW-2:0], n_r[s][i][QW-1-s]};
          n_r[s+1][i] <= n_r[s][i];
          if (t >= RW'(d2_r[s])) begin
            rm_r[s+1][i] <= t - RW'(d2_r[s]);
            q_r[s+1][i] <= {q_r[s][i][QW-2:0], 1'b1};
          end else begin
            rm_r[s+1][i] <= t;
            q_r[s+1][i] <= {q_r[s][i][QW-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign vld_out = v_r[NSTEP];
  assign st = s_r[NSTEP];
  assign quo = q_r[NSTEP];
endmodule
`default_nettype wire

// File: dv/tb_small_matrix_inverse.sv
// ----------------------------------------------------------------------------
// tb_small_matrix_inverse
// Self-checking bench for the 1x1/2x2/3x3 fixed-point matrix inverse. A
// directed table covers the field extremes, each order, singular matrices,
// invalid orders and saturation. Random matrices follow: well-conditioned,
// singular, tiny and raw noise. Every result is checked field by field against
// the table's expected value or an exact wide-integer model of the inverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_small_matrix_inverse;
  import smi_pkg::*;

  typedef logic signed [255:0] wide_t;
  typedef logic [8:0][31:0] mat_t;

  typedef struct packed {
    mat_t r;
    logic sing;
    logic ovf;
  } inv_t;

  typedef struct packed {
    logic [1:0] ord;
    mat_t m;
    logic typed;
    inv_t want;
  } row_t;

  localparam int N_RANDOM = 1530;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] ORD_NONE = 2'd0;
  localparam logic [31:0] ONE = 32'h0001_0000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [295:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [287:0] out_tdata;
  logic [1:0] out_tuser;

  inv_t expected_inverses[$];
  row_t directed_rows[$];
  int n_errors = 0;
  int n_results = 0;
  int n_sing = 0;
  int n_ovf = 0;
  int cycles = 0;
  logic held_long = 1'b0;

  always #2 clk = ~clk;

  small_matrix_inverse dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // exact inverse: cofactor * 2^(2*FB) / det, rounded half away from zero
  function automatic inv_t predict_inverse(logic [1:0] ord, mat_t m);
    wide_t a[9];
    wide_t c[9];
    wide_t det, n, d, q, lim;
    logic neg;
    inv_t res;
    res = '0;
    for (int k = 0; k < 9; k++) begin
      a[k] = wide_t'($signed(m[k]));
      c[k] = '0;
    end
    det = '0;
    case (ord)
      ORD_1: begin
        c[0] = 1;
        det = a[0];
      end
      ORD_2: begin
        c[0] = a[4];
        c[1] = -a[1];
        c[3] = -a[3];
        c[4] = a[0];
        det = a[0] * a[4] - a[1] * a[3];
      end
      ORD_3: begin
        c[0] = a[4] * a[8] - a[5] * a[7];
        c[1] = a[2] * a[7] - a[1] * a[8];
        c[2] = a[1] * a[5] - a[2] * a[4];
        c[3] = a[5] * a[6] - a[3] * a[8];
        c[4] = a[0] * a[8] - a[2] * a[6];
        c[5] = a[2] * a[3] - a[0] * a[5];
        c[6] = a[3] * a[7] - a[4] * a[6];
        c[7] = a[1] * a[6] - a[0] * a[7];
        c[8] = a[0] * a[4] - a[1] * a[3];
        det = a[0] * c[0] + a[1] * c[3] + a[2] * c[6];
      end
      default: det = '0;
    endcase
    if (det == 0) begin
      res.sing = 1'b1;
      return res;
    end
    for (int k = 0; k < 9; k++) begin
      n = c[k] <<< (2 * FB);
      neg = (n != 0) && ((n < 0) != (det < 0));
      if (n < 0) n = -n;
      d = (det < 0) ? -det : det;
      q = (2 * n + d) / (2 * d);
      if (q == 0) neg = 1'b0;
      lim = neg ? wide_t'(64'h8000_0000) : wide_t'(64'h7fff_ffff);
      if (q > lim) begin
        q = lim;
        res.ovf = 1'b1;
      end
      res.r[k] = neg ? -q[31:0] : q[31:0];
    end
    return res;
  endfunction

  task automatic add_row(logic [1:0] ord, mat_t m, logic typed, inv_t want);
    row_t row;
    row.ord = ord;
    row.m = m;
    row.typed = typed;
    row.want = want;
    directed_rows.push_back(row);
  endtask

  function automatic mat_t diag(logic [31:0] v);
    mat_t m;
    m = '0;
    m[0] = v;
    m[4] = v;
    m[8] = v;
    return m;
  endfunction

  function automatic inv_t scalar_inv(logic [31:0] v, logic ovf);
    inv_t r;
    r = '0;
    r.r[0] = v;
    r.ovf = ovf;
    return r;
  endfunction

  function automatic logic [31:0] rand_entry(int mode);
    case (mode)
      0: return 32'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000);
      1: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h0000_0200)) - 32'sh100);
    endcase
  endfunction

  // random matrix: well-conditioned, singular, tiny or noise
  function automatic mat_t rand_matrix(logic [1:0] ord);
    mat_t m;
    int kind;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 9; k++)
      m[k] = rand_entry(kind < 5 ? 0 : (kind < 8 ? 1 : 2));
    if (kind < 4) begin
      // diagonal boost keeps det well away from zero
      m[0] = m[0] + 32'h0010_0000;
      m[4] = m[4] + 32'h0010_0000;
      m[8] = m[8] + 32'h0010_0000;
    end else if (kind == 4) begin
      // duplicate row forces a zero determinant for orders 2 and 3
      if (ord == ORD_3) begin
        m[6] = m[0]; m[7] = m[1]; m[8] = m[2];
      end else begin
        m[3] = m[0]; m[4] = m[1];
      end
    end
    return m;
  endfunction

  task automatic send_request(logic [1:0] ord, mat_t m, logic typed, inv_t want);
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {6'b0, m, ord};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_inverses.push_back(typed ? want : predict_inverse(ord, m));
  endtask

  // stimulus
  initial begin
    inv_t none;
    inv_t ident;
    mat_t m;
    logic [1:0] ord;
    none = '0;
    none.sing = 1'b1;
    ident = '0;
    ident.r = diag(ONE);

    add_row(ORD_1, diag(ONE), 1'b1, scalar_inv(ONE, 1'b0));
    add_row(ORD_1, '0, 1'b1, none);
    add_row(ORD_NONE, diag(ONE), 1'b1, none);
    add_row(ORD_1, diag(32'h1), 1'b1, scalar_inv(32'h7fff_ffff, 1'b1));
    add_row(ORD_1, diag(32'hffff_ffff), 1'b1, scalar_inv(32'h8000_0000, 1'b1));
    add_row(ORD_1, diag(32'h8000_0000), 1'b1, scalar_inv(32'hffff_fffe, 1'b0));
    add_row(ORD_1, diag(32'h7fff_ffff), 1'b0, none);
    add_row(ORD_2, '0 | {32'h0, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, ONE},
            1'b1, '0 | {32'h0, 32'h0, 32'h0, 32'h0, ONE, 32'h0, 32'h0, 32'h0, ONE, 2'b00});
    add_row(ORD_3, diag(ONE), 1'b1, ident);
    add_row(ORD_3, {9{32'h7fff_ffff}}, 1'b1, none);
    add_row(ORD_2, {9{32'h8000_0000}}, 1'b1, none);
    add_row(ORD_2, {32'h0, 32'h0, 32'h0, 32'h0, 32'h7fff_ffff, 32'h8000_0000,
                    32'h0, 32'h8000_0000, 32'h7fff_ffff}, 1'b0, none);
    add_row(ORD_3, {32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'h8000_0000, 32'h7fff_ffff,
                    32'hffff_ffff, 32'h1, 32'h0, 32'h7fff_ffff}, 1'b0, none);
    add_row(ORD_3, diag(32'h0000_0002), 1'b0, none);
    add_row(ORD_3, diag(32'h8000_0000), 1'b0, none);
    // entries outside the order must be ignored
    add_row(ORD_2, {32'hdead_beef, 32'h1234_5678, 32'hffff_ffff, 32'h8000_0000,
                    ONE, 32'h0002_0000, 32'h7fff_ffff, 32'h0003_0000, ONE}, 1'b0, none);
    add_row(ORD_3, {32'h0003_0000, 32'hfffe_0000, ONE, 32'h0002_0000, ONE,
                    32'hffff_0000, ONE, 32'h0002_0000, 32'h0004_0000}, 1'b0, none);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_request(directed_rows[i].ord, directed_rows[i].m,
                   directed_rows[i].typed, directed_rows[i].want);

    for (int i = 0; i < N_RANDOM; i++) begin
      // one drain: hold the sender until the pipeline is empty
      if (i == 800) begin
        in_tvalid <= 1'b0;
        while (expected_inverses.size() != 0) @(posedge clk);
      end
      ord = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(0, 3))
                                         : 2'($urandom_range(1, 3));
      m = rand_matrix(ord);
      send_request(ord, m, 1'b0, none);
    end
    in_tvalid <= 1'b0;

    while (expected_inverses.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d inverses of order 0..3: %0d singular, %0d saturated.",
             n_results, n_sing, n_ovf);
    $display("Random matrices mixed well-conditioned, singular, tiny and raw noise.");
    if (n_errors == 0 && expected_inverses.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // result side ready: random stalls, one long hold-off
  initial begin
    int stall;
    @(posedge clk);
    forever begin
      if (!held_long && n_results >= 300) begin
        held_long = 1'b1;
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // compare each accepted result with the oldest expected inverse
  always @(posedge clk) begin
    inv_t want;
    if (rst_n && out_tvalid && out_tready) begin
      n_results++;
      if (expected_inverses.size() == 0) begin
        $error("unexpected result request");
        n_errors++;
      end else begin
        want = expected_inverses.pop_front();
        if (want.sing) n_sing++;
        if (want.ovf) n_ovf++;
        for (int k = 0; k < 9; k++)
          if (out_tdata[32*k +: 32] !== want.r[k]) begin
            $error("r%0d%0d: expected %h, got %h", k / 3, k % 3,
                   want.r[k], out_tdata[32*k +: 32]);
            n_errors++;
          end
        if (out_tuser[0] !== want.sing) begin
          $error("singular: expected %b, got %b", want.sing, out_tuser[0]);
          n_errors++;
        end
        if (out_tuser[1] !== want.ovf) begin
          $error("overflow: expected %b, got %b", want.ovf, out_tuser[1]);
          n_errors++;
        end
      end
    end
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end
endmodule
`default_nettype wire
